// File: rtl/assert_macros.svh
// Assertion macros shared by the tree ancestor RTL.
// Concurrent checks in simulation; empty bodies in synthesis builds.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TKAL_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("tkal assertion failed");
`define TKAL_ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
        else $error("tkal forbidden condition seen");
`else
`define TKAL_ASSERT(lbl, clk, rstn, prop)
`define TKAL_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

// File: rtl/tkal_pkg.sv
// Shared types and constants for the binary-lifting ancestor engine.
// No dependencies; used by the table RAM, the sequencer and the top level.
`timescale 1ns / 1ps

package tkal_pkg;

    localparam int DEF_NODES  = 65536;
    localparam int DEF_LEVELS = 16;

    localparam int IDX_W     = 16;
    localparam int COUNT_W   = 17;
    localparam int CMP_W     = 21;

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_BUILD = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;

    typedef struct packed {
        logic             none;
        logic [IDX_W-1:0] idx;
    } entry_t;

    typedef struct packed {
        logic             none_found;
        logic [IDX_W-1:0] ancestor;
    } result_t;

endpackage

// File: rtl/tkal_table_ram.sv
// Single-port jump table memory with registered read data.
// Depends on tkal_pkg for the entry type.
`timescale 1ns / 1ps

module tkal_table_ram #(
    parameter int AW = 20
) (
    input  logic             aclk,
    input  logic             rd_en,
    input  logic             wr_en,
    input  logic [AW-1:0]    addr,
    input  tkal_pkg::entry_t wdata,
    output tkal_pkg::entry_t rdata
);
    import tkal_pkg::*;

    localparam int DEPTH = 2 ** AW;

    entry_t mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= wdata;
        end
        if (rd_en) begin
            rdata <= mem[addr];
        end
    end

endmodule

// File: rtl/tkal_seq.sv
// Sequencer for loads, table builds and ancestor queries over one table port.
// Depends on tkal_pkg; drives tkal_table_ram.
`timescale 1ns / 1ps

module tkal_seq #(
    parameter int NODES  = tkal_pkg::DEF_NODES,
    parameter int LEVELS = tkal_pkg::DEF_LEVELS,
    parameter int NW     = (NODES > 1) ? $clog2(NODES) : 1,
    parameter int LW     = (LEVELS > 1) ? $clog2(LEVELS) : 1
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   in_mode,
    input  logic [tkal_pkg::IDX_W-1:0]   in_node,
    input  logic [tkal_pkg::IDX_W-1:0]   in_value,
    input  logic                         in_no_parent,
    input  logic [tkal_pkg::COUNT_W-1:0] node_count,
    output logic                         res_valid,
    input  logic                         res_ready,
    output tkal_pkg::result_t            res,
    output logic                         ram_rd,
    output logic                         ram_we,
    output logic [NW+LW-1:0]             ram_addr,
    output tkal_pkg::entry_t             ram_wdata,
    input  tkal_pkg::entry_t             ram_rdata
);
    import tkal_pkg::*;

    localparam int KW = (LEVELS > IDX_W) ? LEVELS : IDX_W;
    localparam logic [CMP_W-1:0] NODES_C   = CMP_W'(NODES);
    localparam logic [LW-1:0]    TOP       = LW'(LEVELS - 1);
    localparam logic [KW-1:0]    TOPSPAN   = KW'(1) << (LEVELS - 1);
    localparam bit               ONE_LEVEL = (LEVELS == 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_TOP  = 4'd1;
    localparam logic [3:0] S_TOPW = 4'd2;
    localparam logic [3:0] S_LOW  = 4'd3;
    localparam logic [3:0] S_LOWW = 4'd4;
    localparam logic [3:0] S_BRD  = 4'd5;
    localparam logic [3:0] S_BW1  = 4'd6;
    localparam logic [3:0] S_BW2  = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    logic [3:0]       state_reg, state_next;
    logic [NW-1:0]    x_reg, x_next;
    logic [KW-1:0]    k_reg, k_next;
    logic [LW-1:0]    lvl_reg, lvl_next;
    logic [NW-1:0]    i_reg, i_next;
    logic [CMP_W-1:0] n_reg, n_next;
    result_t          res_reg, res_next;

    logic [CMP_W-1:0] node_ext, value_ext, e_ext, cnt_ext, n_eff;
    logic [NW-1:0]    node_n, e_node;
    logic             node_ok, e_bad, last_i, last_lvl;

    assign node_ext  = CMP_W'(in_node);
    assign value_ext = CMP_W'(in_value);
    assign e_ext     = CMP_W'(ram_rdata.idx);
    assign cnt_ext   = CMP_W'(node_count);
    assign node_n    = node_ext[NW-1:0];
    assign e_node    = e_ext[NW-1:0];
    assign node_ok   = node_ext < NODES_C;
    assign e_bad     = ram_rdata.none || (e_ext >= NODES_C);
    assign n_eff     = (cnt_ext > NODES_C) ? NODES_C : cnt_ext;
    assign last_i    = (CMP_W'(i_reg) + CMP_W'(1)) == n_reg;
    assign last_lvl  = lvl_reg == TOP;

    assign in_ready  = state_reg == S_IDLE;
    assign res_valid = state_reg == S_OUT;
    assign res       = res_reg;

    always_comb begin
        state_next = state_reg;
        x_next     = x_reg;
        k_next     = k_reg;
        lvl_next   = lvl_reg;
        i_next     = i_reg;
        n_next     = n_reg;
        res_next   = res_reg;
        ram_rd     = 1'b0;
        ram_we     = 1'b0;
        ram_addr   = {x_reg, lvl_reg};
        ram_wdata  = '0;
        unique case (state_reg) inside
            S_IDLE: begin
                if (in_valid) begin
                    unique case (in_mode)
                        MODE_LOAD: begin
                            if (node_ok) begin
                                ram_we   = 1'b1;
                                ram_addr = {node_n, LW'(0)};
                                if (in_no_parent || value_ext >= NODES_C) begin
                                    ram_wdata.none = 1'b1;
                                end else begin
                                    ram_wdata.idx = in_value;
                                end
                            end
                        end
                        MODE_BUILD: begin
                            if (n_eff != '0 && !ONE_LEVEL) begin
                                n_next     = n_eff;
                                i_next     = '0;
                                lvl_next   = LW'(1);
                                state_next = S_BRD;
                            end
                        end
                        MODE_QUERY: begin
                            if (node_ok) begin
                                x_next     = node_n;
                                k_next     = KW'(in_value);
                                state_next = S_TOP;
                            end else begin
                                res_next   = '{none_found: 1'b1, ancestor: '0};
                                state_next = S_OUT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_TOP: begin
                if (k_reg >= TOPSPAN) begin
                    ram_rd     = 1'b1;
                    ram_addr   = {x_reg, TOP};
                    state_next = S_TOPW;
                end else if (ONE_LEVEL) begin
                    res_next   = '{none_found: 1'b0, ancestor: IDX_W'(x_reg)};
                    state_next = S_OUT;
                end else begin
                    lvl_next   = TOP - LW'(1);
                    state_next = S_LOW;
                end
            end
            S_TOPW: begin
                if (e_bad) begin
                    res_next   = '{none_found: 1'b1, ancestor: '0};
                    state_next = S_OUT;
                end else begin
                    x_next     = e_node;
                    k_next     = k_reg - TOPSPAN;
                    state_next = S_TOP;
                end
            end
            S_LOW: begin
                if (k_reg[lvl_reg]) begin
                    ram_rd     = 1'b1;
                    ram_addr   = {x_reg, lvl_reg};
                    state_next = S_LOWW;
                end else if (lvl_reg == '0) begin
                    res_next   = '{none_found: 1'b0, ancestor: IDX_W'(x_reg)};
                    state_next = S_OUT;
                end else begin
                    lvl_next = lvl_reg - LW'(1);
                end
            end
            S_LOWW: begin
                if (e_bad) begin
                    res_next   = '{none_found: 1'b1, ancestor: '0};
                    state_next = S_OUT;
                end else if (lvl_reg == '0) begin
                    res_next   = '{none_found: 1'b0, ancestor: ram_rdata.idx};
                    state_next = S_OUT;
                end else begin
                    x_next     = e_node;
                    lvl_next   = lvl_reg - LW'(1);
                    state_next = S_LOW;
                end
            end
            S_BRD: begin
                ram_rd     = 1'b1;
                ram_addr   = {i_reg, lvl_reg - LW'(1)};
                state_next = S_BW1;
            end
            S_BW1, S_BW2: begin
                if (state_reg == S_BW1 && !e_bad) begin
                    ram_rd     = 1'b1;
                    ram_addr   = {e_node, lvl_reg - LW'(1)};
                    state_next = S_BW2;
                end else begin
                    ram_we   = 1'b1;
                    ram_addr = {i_reg, lvl_reg};
                    if (state_reg == S_BW1) begin
                        ram_wdata.none = 1'b1;
                    end else begin
                        ram_wdata = ram_rdata;
                    end
                    if (last_i) begin
                        i_next = '0;
                        if (last_lvl) begin
                            state_next = S_IDLE;
                        end else begin
                            lvl_next   = lvl_reg + LW'(1);
                            state_next = S_BRD;
                        end
                    end else begin
                        i_next     = i_reg + NW'(1);
                        state_next = S_BRD;
                    end
                end
            end
            S_OUT: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg   <= x_next;
        k_reg   <= k_next;
        lvl_reg <= lvl_next;
        i_reg   <= i_next;
        n_reg   <= n_next;
        res_reg <= res_next;
    end

endmodule

// File: rtl/tree_kth_ancestor_lifting.sv
// Top level of the binary-lifting k-th ancestor engine: stream ports,
// node count register, output register. Depends on tkal_pkg, tkal_seq,
// tkal_table_ram and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage:
// Input words on s_*: mode 0 loads one node's parent (or marks a root),
// mode 1 builds all higher jump levels for the first node_count nodes,
// mode 2 asks for the k-th ancestor of a node, mode 3 is dropped.
// Only queries produce an output word on m_*: ancestor in m_tdata and
// the none flag in m_tuser (ancestor reads 0 when the flag is set).
// cfg_* writes node_count; write it only while the block is idle.
// All steps below go through the single-port jump table.
//   load: written straight from the idle state, so s_tready stays high.
//   query: jumps at the top level while k >= 2^(LEVELS-1), then walks the lower
//     levels, ending early when the walk leaves the tree; result registered.
//   build: per entry, reads the lower-level link and, when valid, that ancestor's
//     link, then writes; min(node_count,NODES)*(LEVELS-1) entries.
// s_tready stays low while a build or query runs. A finished result sits in
// the output register until taken; loads and builds proceed meanwhile, but a
// following query holds its result and keeps s_tready low until the slot frees.
// Reset clears control state and sets node_count to 1; table contents are
// undefined until loaded or built.
module tree_kth_ancestor_lifting #(
    parameter int NODES  = tkal_pkg::DEF_NODES,
    parameter int LEVELS = tkal_pkg::DEF_LEVELS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [31:0]                  s_tdata,   // node[15:0], value[31:16]
    input  logic [2:0]                   s_tuser,   // mode[1:0], no_parent[2]
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [15:0]                  m_tdata,   // ancestor[15:0]
    output logic [0:0]                   m_tuser,   // none_found[0]
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [tkal_pkg::COUNT_W-1:0] cfg_data
);
    import tkal_pkg::*;

    localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;

    logic [COUNT_W-1:0] node_count_reg;
    logic               m_valid_reg;
    result_t            m_word_reg;

    logic               res_valid, res_ready;
    result_t            res;
    logic               ram_rd, ram_we;
    logic [NW+LW-1:0]   ram_addr;
    entry_t             ram_wdata, ram_rdata;
    logic               query_acc, res_fire;

    assign cfg_ready = 1'b1;
    assign res_ready = !m_valid_reg || m_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_word_reg.ancestor;
    assign m_tuser   = m_word_reg.none_found;
    assign query_acc = s_tvalid && s_tready && (s_tuser[1:0] == MODE_QUERY);
    assign res_fire  = res_valid && res_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= COUNT_W'(1);
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid) begin
                node_count_reg <= cfg_data;
            end
            if (res_valid && res_ready) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_word_reg <= res;
        end
    end

    tkal_seq #(
        .NODES  (NODES),
        .LEVELS (LEVELS),
        .NW     (NW),
        .LW     (LW)
    ) u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_mode      (s_tuser[1:0]),
        .in_node      (s_tdata[15:0]),
        .in_value     (s_tdata[31:16]),
        .in_no_parent (s_tuser[2]),
        .node_count   (node_count_reg),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res),
        .ram_rd       (ram_rd),
        .ram_we       (ram_we),
        .ram_addr     (ram_addr),
        .ram_wdata    (ram_wdata),
        .ram_rdata    (ram_rdata)
    );

    tkal_table_ram #(
        .AW (NW + LW)
    ) u_table (
        .aclk  (aclk),
        .rd_en (ram_rd),
        .wr_en (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    `TKAL_ASSERT(a_query_busy, aclk, aresetn, query_acc |=> !s_tready)
    `TKAL_ASSERT_NEVER(a_ready_with_result, aclk, aresetn, res_valid && s_tready)
    `TKAL_ASSERT(a_idle_after_result, aclk, aresetn, res_fire |=> (s_tready && !res_valid))

endmodule

// File: dv/tb.sv
// Self-checking bench for tree_kth_ancestor_lifting: loads parent links, builds the
// jump table, and checks every k-th ancestor query against an in-bench lifting table.
// Depends on tkal_pkg and the tree_kth_ancestor_lifting RTL only.
`timescale 1ns / 1ps

module tb;

    localparam int NODES     = tkal_pkg::DEF_NODES;
    localparam int LEVELS    = tkal_pkg::DEF_LEVELS;
    localparam int TOP_SPAN  = 1 << (LEVELS - 1);
    localparam int LOWN      = 24;
    localparam int SETTLE    = LOWN * (LEVELS - 1) * 3 + 64;
    localparam int PER_PHASE = 94;
    localparam int LIMIT     = 1000000;

    localparam logic [1:0] MODE_LOAD  = tkal_pkg::MODE_LOAD;
    localparam logic [1:0] MODE_BUILD = tkal_pkg::MODE_BUILD;
    localparam logic [1:0] MODE_QUERY = tkal_pkg::MODE_QUERY;
    localparam logic [1:0] MODE_SKIP  = 2'd3;

    class ancestor_oracle;
        tkal_pkg::entry_t  lift [NODES*LEVELS];
        logic [16:0]       node_count;
        tkal_pkg::result_t want_q [$];
        int                errors;

        function new();
            node_count = 17'd1;
            errors = 0;
        endfunction

        function int pending();
            return want_q.size();
        endfunction

        function void set_count(logic [16:0] count);
            node_count = count;
        endfunction

        function bit hop(input int from, input int lvl, output int to);
            tkal_pkg::entry_t e;
            e = lift[from*LEVELS + lvl];
            to = from;
            if (e.none || int'(e.idx) >= NODES)
                return 1'b0;
            to = int'(e.idx);
            return 1'b1;
        endfunction

        function void fill_levels();
            int span, lvl, i, a;
            tkal_pkg::entry_t e;
            span = (int'(node_count) > NODES) ? NODES : int'(node_count);
            for (lvl = 1; lvl < LEVELS; lvl++) begin
                for (i = 0; i < span; i++) begin
                    e.none = 1'b1;
                    e.idx = '0;
                    if (hop(i, lvl - 1, a))
                        e = lift[a*LEVELS + lvl - 1];
                    lift[i*LEVELS + lvl] = e;
                end
            end
        endfunction

        function tkal_pkg::result_t walk_up(int start, int k);
            int x, lvl;
            bit ok;
            tkal_pkg::result_t r;
            x = start;
            ok = (start < NODES);
            while (ok && k >= TOP_SPAN) begin
                ok = hop(x, LEVELS - 1, x);
                k -= TOP_SPAN;
            end
            for (lvl = LEVELS - 2; lvl >= 0; lvl--) begin
                if (ok && ((k >> lvl) & 1))
                    ok = hop(x, lvl, x);
            end
            r.none_found = !ok;
            r.ancestor = ok ? x[15:0] : '0;
            return r;
        endfunction

        function void note_word(logic [1:0] mode, logic [15:0] node, logic [15:0] value,
                                logic nop);
            tkal_pkg::entry_t e;
            case (mode)
                MODE_LOAD: begin
                    if (int'(node) < NODES) begin
                        e.none = nop || (int'(value) >= NODES);
                        e.idx = e.none ? '0 : value;
                        lift[int'(node)*LEVELS] = e;
                    end
                end
                MODE_BUILD: fill_levels();
                MODE_QUERY: want_q = {want_q, walk_up(int'(node), int'(value))};
                default: ;
            endcase
        endfunction

        function void check_word(logic [15:0] anc, logic nf);
            tkal_pkg::result_t w;
            if (want_q.size() == 0) begin
                $error("result word with no query outstanding: ancestor %0d none_found %0b",
                       anc, nf);
                errors++;
                return;
            end
            w = want_q.pop_front();
            if (anc !== w.ancestor) begin
                $error("ancestor: expected %0d, got %0d", w.ancestor, anc);
                errors++;
            end
            if (nf !== w.none_found) begin
                $error("none_found: expected %0b, got %0b", w.none_found, nf);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;     // node[15:0], value[31:16]
    logic [2:0]  s_tuser = '0;     // mode[1:0], no_parent[2]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;          // ancestor[15:0]
    logic [0:0]  m_tuser;          // none_found[0]
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [16:0] cfg_data = '0;

    ancestor_oracle oracle = new();
    int             burst_left = 0;
    int             rx_tick = 0;
    int             cycles = 0;
    int             high_nodes [$];
    logic [16:0]    phase_counts [8];

    tree_kth_ancestor_lifting #(
        .NODES  (NODES),
        .LEVELS (LEVELS)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_tick <= 0;
        end else begin
            if (m_tvalid && m_tready)
                oracle.check_word(m_tdata, m_tuser[0]);
            rx_tick <= rx_tick + 1;
            case (rx_tick[11:10])
                2'd0: m_tready <= 1'b1;
                2'd1: m_tready <= ($urandom_range(0, 3) != 0);
                2'd2: m_tready <= ((rx_tick % 7) < 3);
                default: m_tready <= 1'($urandom_range(0, 1));
            endcase
        end
    end

    task automatic send_word(input logic [1:0] mode, input logic [15:0] node,
                             input logic [15:0] value, input logic nop);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {value, node};
        s_tuser <= {nop, mode};
        do @(posedge aclk); while (!s_tready);
        oracle.note_word(mode, node, value, nop);
        burst_left--;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (oracle.pending() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        burst_left = 0;
    endtask

    task automatic write_count(input logic [16:0] count);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data <= count;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        oracle.set_count(count);
    endtask

    // Low nodes keep parents inside the low set so every walk stays on built entries;
    // high nodes only ever have their parent link, so they take k of 0 or 1.
    task automatic random_word(input bit allow_build, output bit counted);
        int          pick;
        logic [1:0]  mode;
        logic [15:0] node, value;
        logic        nop;
        pick = $urandom_range(0, 99);
        node = 16'($urandom);
        value = 16'($urandom);
        nop = 1'($urandom_range(0, 1));
        counted = 1'b1;
        if (pick < 18) begin
            mode = MODE_LOAD;
            node = 16'($urandom_range(0, LOWN - 1));
            nop = ($urandom_range(0, 9) == 0);
            if (!nop)
                value = 16'($urandom_range(0, LOWN - 1));
        end else if (pick < 30) begin
            mode = MODE_LOAD;
            node = 16'($urandom_range(LOWN, 65535));
            nop = ($urandom_range(0, 4) == 0);
            high_nodes = {high_nodes, int'(node)};
        end else if (pick < 36 && allow_build) begin
            mode = MODE_BUILD;
        end else if (pick >= 36 && pick < 40) begin
            mode = MODE_SKIP;
            counted = 1'b0;
        end else if (pick < 52 && high_nodes.size() > 0) begin
            mode = MODE_QUERY;
            node = 16'(high_nodes[$urandom_range(0, high_nodes.size() - 1)]);
            value = 16'($urandom_range(0, 1));
        end else begin
            mode = MODE_QUERY;
            node = 16'($urandom_range(0, LOWN - 1));
            case ($urandom_range(0, 4)) inside
                0, 1: value = 16'($urandom_range(0, 3 * LOWN));
                2: value = 16'($urandom_range(TOP_SPAN - 8, TOP_SPAN + 8));
                3: value = 16'd1 << $urandom_range(0, 15);
                default: value = 16'($urandom);
            endcase
        end
        send_word(mode, node, value, nop);
    endtask

    initial begin
        int i, p, sent;
        bit counted;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // node 0 starts as a root so the first build at the reset count stays in bounds
        send_word(MODE_LOAD, 16'd0, 16'hFFFF, 1'b1);
        for (i = 1; i < LOWN; i++)
            send_word(MODE_LOAD, 16'(i), 16'($urandom_range(0, i - 1)), 1'b0);

        send_word(MODE_BUILD, 16'hFFFF, 16'hFFFF, 1'b1);
        send_word(MODE_QUERY, 16'd0, 16'd0, 1'b0);
        send_word(MODE_QUERY, 16'd0, 16'd1, 1'b1);
        send_word(MODE_QUERY, 16'd0, 16'hFFFF, 1'b0);
        write_count(17'(LOWN));
        send_word(MODE_BUILD, 16'd0, 16'd0, 1'b0);
        send_word(MODE_QUERY, 16'(LOWN - 1), 16'd0, 1'b0);
        send_word(MODE_QUERY, 16'(LOWN - 1), 16'd1, 1'b0);
        send_word(MODE_QUERY, 16'(LOWN - 1), 16'd2, 1'b0);
        send_word(MODE_QUERY, 16'(LOWN - 1), 16'd3, 1'b0);
        send_word(MODE_QUERY, 16'(LOWN - 1), 16'(TOP_SPAN - 1), 1'b0);
        send_word(MODE_QUERY, 16'(LOWN - 1), 16'(TOP_SPAN), 1'b0);
        send_word(MODE_QUERY, 16'(LOWN - 1), 16'hFFFF, 1'b1);
        send_word(MODE_LOAD, 16'hFFFF, 16'hFFFF, 1'b0);
        high_nodes = {high_nodes, int'(16'hFFFF)};
        send_word(MODE_QUERY, 16'hFFFF, 16'd1, 1'b0);
        send_word(MODE_QUERY, 16'hFFFF, 16'd0, 1'b1);
        send_word(MODE_LOAD, 16'h8000, 16'd0, 1'b1);
        high_nodes = {high_nodes, int'(16'h8000)};
        send_word(MODE_QUERY, 16'h8000, 16'd1, 1'b0);
        send_word(MODE_SKIP, 16'hFFFF, 16'hFFFF, 1'b1);
        send_word(MODE_LOAD, 16'd0, 16'(LOWN - 1), 1'b0);
        send_word(MODE_BUILD, 16'd0, 16'd0, 1'b0);
        send_word(MODE_QUERY, 16'd0, 16'hFFFF, 1'b0);

        // big counts would sweep never-loaded nodes, so those phases hold off builds
        phase_counts = '{17'(LOWN), 17'd0, 17'd1, 17'd65536, 17'h1FFFF,
                         17'($urandom_range(2, LOWN - 1)), 17'd7, 17'(LOWN)};
        for (p = 0; p < 8; p++) begin
            write_count(phase_counts[p]);
            sent = 0;
            while (sent < PER_PHASE) begin
                random_word(phase_counts[p] <= LOWN, counted);
                sent += int'(counted);
            end
        end

        wait_idle();
        if (oracle.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/tkal_pkg.sv
rtl/tkal_table_ram.sv
rtl/tkal_seq.sv
rtl/tree_kth_ancestor_lifting.sv
dv/tb.sv
